FILE: rtl/dtpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking pointer map package
// Shared widths, constants, register codes, controller states and commands.
// ----------------------------------------------------------------------------
package dtpm_pkg;

  localparam int DT_W      = 16;
  localparam int DTC_W     = 7;
  localparam int GAIN_W    = 12;
  localparam int SPEED_W   = 12;
  localparam int THR_W     = 9;
  localparam int DZ_W      = 16;
  localparam int MARGIN_W  = 16;
  localparam int INV_W     = 2;
  localparam int MOVE_W    = 16;
  localparam int DIR_W     = 2;
  localparam int EC_W      = 4;
  localparam int PP_W      = SPEED_W + DTC_W;
  localparam int RCP_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DT_CAP_MS   = 100;
  localparam int DT_SUB_MS   = 10;
  localparam int MIN_RANGE   = 1000;
  localparam int SUB_RANGE   = 100000;
  localparam int LIMIT_RESET = 60000;
  localparam int PUSH_DIV    = 1000;
  localparam int MOVE_MAX    = 32767;
  localparam int MOVE_MIN_MAG = 32768;

  // The rounded-up reciprocal of PUSH_DIV is exact for every push product.
  localparam int PUSH_SHIFT  = 29;
  localparam int PUSH_RECIP  = 536871;
  localparam int STEP_W      = PP_W + RCP_W - PUSH_SHIFT;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(500);
  localparam logic [SPEED_W-1:0]  SPEED_RST  = SPEED_W'(1000);
  localparam logic [THR_W-1:0]    THR_RST    = THR_W'(218);
  localparam logic [DZ_W-1:0]     DZ_RST     = DZ_W'(328);
  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(1000);
  localparam logic [INV_W-1:0]    INV_RST    = '0;

  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_NEG  = 2'sb11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X,
    REG_GAIN_Y,
    REG_SPEED_X,
    REG_SPEED_Y,
    REG_PUSH_THR,
    REG_DEADZONE,
    REG_MARGIN,
    REG_INVERT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic start;
    logic fin;
  } cmd_t;

endpackage

FILE: rtl/dtpm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking pointer map channels
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface dtpm_in_if #(parameter int POS_BITS = 18) ();
  import dtpm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic [DT_W-1:0]            dt_ms;
  modport source (output valid, pos_x, pos_y, dt_ms, input ready);
  modport sink (input valid, pos_x, pos_y, dt_ms, output ready);
endinterface

interface dtpm_out_if ();
  import dtpm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;
  logic signed [DIR_W-1:0]  push_dir_x;
  logic signed [DIR_W-1:0]  push_dir_y;
  modport source (output valid, move_x, move_y, push_dir_x, push_dir_y, input ready);
  modport sink (input valid, move_x, move_y, push_dir_x, push_dir_y, output ready);
endinterface

interface dtpm_cfg_if ();
  import dtpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

FILE: rtl/dtpm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking pointer map divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtpm_div #(
  parameter int DW = 31,
  parameter int VW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   part;
  logic [VW:0]   trial;
  logic          ge;

  assign part  = {rem_r, quo_r[DW-1]};
  assign ge    = part >= {1'b0, dvs_r};
  assign trial = part - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CW'(DW);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? trial[VW-1:0] : part[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == '0);

endmodule

FILE: rtl/dtpm_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking pointer map axis datapath
// Limit tracking, offset forming, mode decision and scaled move for one axis.
// ----------------------------------------------------------------------------
module dtpm_axis #(
  parameter int POS_BITS  = 18,
  parameter int EDGE_HOLD = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dtpm_pkg::cmd_t                      cmd,
  input  logic signed [POS_BITS-1:0]          pos,
  input  logic [dtpm_pkg::DTC_W-1:0]          dt,
  input  logic [dtpm_pkg::GAIN_W-1:0]         gain,
  input  logic [dtpm_pkg::SPEED_W-1:0]        push_speed,
  input  logic [dtpm_pkg::THR_W-1:0]          push_thr,
  input  logic [dtpm_pkg::DZ_W-1:0]           deadzone,
  input  logic [dtpm_pkg::MARGIN_W-1:0]       margin,
  input  logic                                invert,
  output logic                                div_done,
  output logic signed [dtpm_pkg::MOVE_W-1:0]  move,
  output logic signed [dtpm_pkg::DIR_W-1:0]   dir
);
  import dtpm_pkg::*;

  localparam int LW = (POS_BITS > 18) ? POS_BITS : 18;
  localparam int MW = LW + 1;
  localparam int DW = MW + GAIN_W;

  logic signed [LW-1:0] low_r, high_r, prior_r, v_r;
  logic [EC_W-1:0]      cnt_r;

  logic signed [LW-1:0] pos_ext;
  logic signed [LW:0]   v_w, marg_s, hi_edge, lo_edge;
  logic                 at_high, at_low;
  logic [EC_W-1:0]      cnt_inc;
  logic                 hold;

  logic signed [LW:0]   range_raw, min_rng;
  logic [LW-1:0]        range_sel;
  logic [LW+1:0]        num_w, mag_full;
  logic                 num_neg;

  logic [LW-1:0]        range_r;
  logic [MW-1:0]        mag_r;
  logic                 neg_r, nz_r;

  logic [LW+8:0]        thr_prod_r;
  logic [LW+15:0]       dz_prod_r;
  logic [DW-1:0]        gain_prod_r;
  logic [PP_W-1:0]      push_prod_r;

  logic                 push_w, norm_w;
  logic [DW-1:0]        dvd_w;
  logic [LW-1:0]        dvs_w;
  logic                 mneg_r;
  logic signed [DIR_W-1:0] dir_r;

  logic [PP_W+RCP_W-1:0] step_prod;
  logic [STEP_W-1:0]     step_r;
  logic                  push_r;

  logic [DW-1:0]        quo;
  logic [DW-1:0]        mag_q;
  logic                 out_neg;

  assign pos_ext = LW'(pos);
  assign v_w     = {pos_ext[LW-1], pos_ext};
  assign marg_s  = {{(LW + 1 - MARGIN_W){1'b0}}, margin};
  assign hi_edge = {high_r[LW-1], high_r} - marg_s;
  assign lo_edge = {low_r[LW-1], low_r} + marg_s;
  assign at_high = (v_w >= hi_edge) && (pos_ext > prior_r);
  assign at_low  = (v_w <= lo_edge) && (pos_ext < prior_r);
  assign cnt_inc = cnt_r + 1'b1;
  assign hold    = cnt_inc > EC_W'(EDGE_HOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= LW'(-LIMIT_RESET);
      high_r  <= LW'(LIMIT_RESET);
      prior_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.load) begin
      prior_r <= pos_ext;
      if (at_high || at_low) begin
        if (hold) begin
          cnt_r <= '0;
          if (at_high) begin
            high_r <= pos_ext;
          end else begin
            low_r <= pos_ext;
          end
        end else begin
          cnt_r <= cnt_inc;
        end
      end else begin
        cnt_r <= '0;
      end
    end
  end

  assign range_raw = {high_r[LW-1], high_r} - {low_r[LW-1], low_r};
  assign min_rng   = (LW + 1)'(MIN_RANGE);
  assign range_sel = (range_raw < min_rng) ? LW'(SUB_RANGE) : range_raw[LW-1:0];
  assign num_w     = {v_r[LW-1], v_r, 1'b0} - {{2{low_r[LW-1]}}, low_r}
                     - {{2{high_r[LW-1]}}, high_r};
  assign num_neg   = num_w[LW+1];
  assign mag_full  = num_neg ? (~num_w + 1'b1) : num_w;

  assign push_w = {mag_r, 8'b0} >= thr_prod_r;
  assign norm_w = {mag_r, 16'b0} > {1'b0, dz_prod_r};
  assign dvd_w  = (norm_w && !push_w) ? gain_prod_r : '0;
  assign dvs_w  = range_r;

  assign step_prod = (PP_W + RCP_W)'(push_prod_r) * (PP_W + RCP_W)'(PUSH_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= pos_ext;
    end
    if (cmd.prep) begin
      range_r <= range_sel;
      mag_r   <= mag_full[MW-1:0];
      neg_r   <= num_neg;
      nz_r    <= |num_w;
    end
    if (cmd.mul) begin
      thr_prod_r  <= (LW + 9)'(push_thr) * range_r;
      dz_prod_r   <= (LW + 16)'(deadzone) * range_r;
      gain_prod_r <= DW'(gain) * mag_r;
      push_prod_r <= PP_W'(push_speed) * PP_W'(dt);
    end
    if (cmd.start) begin
      push_r <= push_w;
      step_r <= step_prod[PP_W+RCP_W-1:PUSH_SHIFT];
      if (push_w) begin
        dir_r  <= (nz_r && !neg_r) ? DIR_POS : DIR_NEG;
        mneg_r <= !(nz_r && !neg_r);
      end else begin
        dir_r  <= DIR_NONE;
        mneg_r <= neg_r;
      end
    end
  end

  dtpm_div #(
    .DW (DW),
    .VW (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (dvd_w),
    .divisor  (dvs_w),
    .quotient (quo),
    .done     (div_done)
  );

  assign mag_q   = push_r ? DW'(step_r) : quo;
  assign out_neg = mneg_r ^ invert;

  always_comb begin
    if (!out_neg) begin
      move = (mag_q > DW'(MOVE_MAX)) ? MOVE_W'(MOVE_MAX) : mag_q[MOVE_W-1:0];
    end else begin
      move = (mag_q > DW'(MOVE_MIN_MAG)) ? MOVE_W'(-MOVE_MIN_MAG) : -mag_q[MOVE_W-1:0];
    end
  end

  assign dir = dir_r;

endmodule

FILE: rtl/dtpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking pointer map controller
// Sequences capture, offset forming, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module dtpm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           div_done,
  input  logic           out_free,
  output logic           in_ready,
  output dtpm_pkg::cmd_t cmd
);
  import dtpm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PREP:  cmd.prep  = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_START: cmd.start = 1'b1;
      ST_DIV:   ;
      ST_FIN:   cmd.fin   = out_free;
      default:  ;
    endcase
  end

endmodule

FILE: rtl/drift_tracking_hybrid_pointer_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking hybrid pointer map
// Tracks drifting X/Y limits and maps each sample to a pixel move or push.
// ----------------------------------------------------------------------------
// A new sample is taken only once the previous one has reached the result register.
// Each axis has a bit-serial divider producing one quotient bit a cycle.
// The result register lets the next sample start while a result waits.
// Synchronous active-low reset restores register defaults, limits of +/-60000,
// zero prior samples and counts, and drops the result valid.
module drift_tracking_hybrid_pointer_map_unit #(
  parameter int POS_BITS  = 18,
  parameter int EDGE_HOLD = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  dtpm_in_if.sink      in_chan,
  dtpm_out_if.source   out_chan,
  dtpm_cfg_if.sink     cfg_chan
);
  import dtpm_pkg::*;

  logic [GAIN_W-1:0]   gain_x_r, gain_y_r;
  logic [SPEED_W-1:0]  speed_x_r, speed_y_r;
  logic [THR_W-1:0]    thr_r;
  logic [DZ_W-1:0]     dz_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [INV_W-1:0]    inv_r;
  logic [DTC_W-1:0]    dt_r;

  logic                     out_valid_r;
  logic signed [MOVE_W-1:0] move_x_r, move_y_r;
  logic signed [DIR_W-1:0]  dir_x_r, dir_y_r;

  cmd_t                     cmd;
  logic                     in_ready;
  logic                     done_x, done_y;
  logic                     out_free;
  logic signed [MOVE_W-1:0] move_x, move_y;
  logic signed [DIR_W-1:0]  dir_x, dir_y;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r  <= GAIN_RST;
      gain_y_r  <= GAIN_RST;
      speed_x_r <= SPEED_RST;
      speed_y_r <= SPEED_RST;
      thr_r     <= THR_RST;
      dz_r      <= DZ_RST;
      margin_r  <= MARGIN_RST;
      inv_r     <= INV_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_reg_t'(cfg_chan.idx))
        REG_GAIN_X:   gain_x_r  <= cfg_chan.data[GAIN_W-1:0];
        REG_GAIN_Y:   gain_y_r  <= cfg_chan.data[GAIN_W-1:0];
        REG_SPEED_X:  speed_x_r <= cfg_chan.data[SPEED_W-1:0];
        REG_SPEED_Y:  speed_y_r <= cfg_chan.data[SPEED_W-1:0];
        REG_PUSH_THR: thr_r     <= cfg_chan.data[THR_W-1:0];
        REG_DEADZONE: dz_r      <= cfg_chan.data[DZ_W-1:0];
        REG_MARGIN:   margin_r  <= cfg_chan.data[MARGIN_W-1:0];
        REG_INVERT:   inv_r     <= cfg_chan.data[INV_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r <= (in_chan.dt_ms > DT_W'(DT_CAP_MS)) ? DTC_W'(DT_SUB_MS)
                                                 : in_chan.dt_ms[DTC_W-1:0];
    end
  end

  assign in_chan.ready = in_ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  dtpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .div_done (done_x && done_y),
    .out_free (out_free),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dtpm_axis #(
    .POS_BITS  (POS_BITS),
    .EDGE_HOLD (EDGE_HOLD)
  ) u_axis_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .pos        (in_chan.pos_x),
    .dt         (dt_r),
    .gain       (gain_x_r),
    .push_speed (speed_x_r),
    .push_thr   (thr_r),
    .deadzone   (dz_r),
    .margin     (margin_r),
    .invert     (inv_r[0]),
    .div_done   (done_x),
    .move       (move_x),
    .dir        (dir_x)
  );

  dtpm_axis #(
    .POS_BITS  (POS_BITS),
    .EDGE_HOLD (EDGE_HOLD)
  ) u_axis_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .pos        (in_chan.pos_y),
    .dt         (dt_r),
    .gain       (gain_y_r),
    .push_speed (speed_y_r),
    .push_thr   (thr_r),
    .deadzone   (dz_r),
    .margin     (margin_r),
    .invert     (inv_r[1]),
    .div_done   (done_y),
    .move       (move_y),
    .dir        (dir_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      move_x_r <= move_x;
      move_y_r <= move_y;
      dir_x_r  <= dir_x;
      dir_y_r  <= dir_y;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.move_x     = move_x_r;
  assign out_chan.move_y     = move_y_r;
  assign out_chan.push_dir_x = dir_x_r;
  assign out_chan.push_dir_y = dir_y_r;

endmodule

FILE: rtl/dtpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift tracking pointer map checker
// Port-level assertions on handshakes and result encoding, bound to the top.
// ----------------------------------------------------------------------------
module dtpm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dtpm_pkg::MOVE_W-1:0]  move_x,
  input logic signed [dtpm_pkg::MOVE_W-1:0]  move_y,
  input logic signed [dtpm_pkg::DIR_W-1:0]   push_dir_x,
  input logic signed [dtpm_pkg::DIR_W-1:0]   push_dir_y
);
  import dtpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before its transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(move_x) && $stable(move_y)
      && $stable(push_dir_x) && $stable(push_dir_y))
    else $error("stalled result changed");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> push_dir_x != 2'sb10 && push_dir_y != 2'sb10)
    else $error("push direction outside -1..1");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while previous one is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after a sample transaction");

endmodule

bind drift_tracking_hybrid_pointer_map_unit dtpm_checker u_dtpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .move_x     (out_chan.move_x),
  .move_y     (out_chan.move_y),
  .push_dir_x (out_chan.push_dir_x),
  .push_dir_y (out_chan.push_dir_y)
);
